>>> hw/rtl/tcw_pkg.sv
// shared types and constants of the text console cursor writer
`default_nettype none

package tcw_pkg;

  // command codes carried in in_tuser
  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_COLS = 2'd0,
    CFG_ROWS = 2'd1,
    CFG_ATTR = 2'd2
  } cfg_idx_t;

  // character codes
  localparam logic [7:0] CH_PRINT = 8'd32;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;

  // reset values of the size and attribute registers
  localparam logic [7:0] COLS_RST = 8'd80;
  localparam logic [6:0] ROWS_RST = 7'd25;
  localparam logic [7:0] ATTR_RST = 8'h0F;

  // internal cursor and size width, covers sizes up to 255
  localparam int CUR_W = 8;

  // result layout in out_tdata
  localparam int OUT_COL_LSB  = 0;
  localparam int OUT_COL_W    = 7;
  localparam int OUT_ROW_LSB  = 7;
  localparam int OUT_ROW_W    = 6;
  localparam int OUT_SCRL_BIT = 29;

endpackage

`default_nettype wire

>>> hw/rtl/tcw_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/text_console_cursor_writer_top.sv
// top level of the text console cursor writer
`default_nettype none

// Text console with a cursor: a MAX_ROWS x MAX_COLS cell store (16 bits a
// cell, character in the low byte, attribute in the high byte) in one
// simple dual port ram, plus a cursor. One result comes back for every
// command transaction. A command is accepted in S_IDLE, where the cursor
// is updated and the ram is written or read; in S_OUT the result then goes
// into the output register (read data arrives from the ram's registered
// port by then). The next command is taken while a result still waits in
// the output register. A newline from the bottom row scrolls the rows in
// use: one cell is copied each cycle through the ram, read one row below
// and written back in the cycle after, then the last row is cleared one
// cell a cycle; the single write port sets this pace. After reset a
// clearing pass writes zero to every cell, all MAX_ROWS*MAX_COLS of them
// (8192 at the defaults), during which in_tready is low; configuration
// writes are taken at all times. Sizes saturate to 1..MAX_COLS and
// 1..MAX_ROWS; a set cursor saturates to the last column and row in use.

module text_console_cursor_writer_top
  import tcw_pkg::*;
#(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // char_code[7:0], col[14:8], row[20:15], cell_attr[28:21]
  input  wire logic [1:0]  in_tuser,   // cmd[1:0]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // cursor_col[6:0], cursor_row[12:7], read_char[20:13],
                                       // read_attr[28:21], scrolled[29]
  // configuration port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [AW-1:0]    ROW_STEP  = AW'(MAX_COLS);
  localparam logic [CUR_W-1:0] MAXC      = CUR_W'(MAX_COLS);
  localparam logic [CUR_W-1:0] MAXR      = CUR_W'(MAX_ROWS);

  typedef enum logic [2:0] {
    S_INIT,   // clearing pass after reset
    S_IDLE,   // waiting for a command
    S_COPY,   // scroll: moving rows up
    S_CLEAR,  // scroll: zeroing the last row
    S_OUT     // result waiting for the output register
  } state_t;

  // unpacked command fields
  cmd_t       in_cmd;
  logic [7:0] in_char;
  logic [6:0] in_col;
  logic [5:0] in_row;
  logic [7:0] in_attr;

  assign in_cmd  = cmd_t'(in_tuser);
  assign in_char = in_tdata[7:0];
  assign in_col  = in_tdata[14:8];
  assign in_row  = in_tdata[20:15];
  assign in_attr = in_tdata[28:21];

  // registers
  state_t           state_r,    state_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [CUR_W-1:0] cur_col_r,  cur_col_nxt;
  logic [CUR_W-1:0] cur_row_r,  cur_row_nxt;
  logic [7:0]       cfg_cols_r, cfg_cols_nxt;
  logic [6:0]       cfg_rows_r, cfg_rows_nxt;
  logic [7:0]       cfg_attr_r, cfg_attr_nxt;
  logic             scrolled_r, scrolled_nxt;
  logic             rd_ok_r,    rd_ok_nxt;
  logic [CUR_W-1:0] sc_col_r,   sc_col_nxt;
  logic [CUR_W-1:0] sc_row_r,   sc_row_nxt;
  logic [AW-1:0]    row_base_r, row_base_nxt;
  logic             wb_valid_r, wb_valid_nxt;
  logic [AW-1:0]    wb_addr_r,  wb_addr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_data_r,  out_data_nxt;

  // ram port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  // derived values
  logic [CUR_W-1:0] eff_cols, eff_rows;
  logic [CUR_W-1:0] last_col, last_row;
  logic [CUR_W:0]   col_inc, line_inc;
  logic             cur_in_store, pos_in_store;
  logic [AW-1:0]    cur_addr, pos_addr;
  logic             in_acc;
  logic             newline;
  logic [7:0]       rd_char, rd_attr;

  // sizes saturate to the store, zero counts as one
  always_comb begin
    if (cfg_cols_r == '0) begin
      eff_cols = CUR_W'(1);
    end else if (cfg_cols_r > MAXC) begin
      eff_cols = MAXC;
    end else begin
      eff_cols = cfg_cols_r;
    end
    if (cfg_rows_r == '0) begin
      eff_rows = CUR_W'(1);
    end else if ({1'b0, cfg_rows_r} > MAXR) begin
      eff_rows = MAXR;
    end else begin
      eff_rows = {1'b0, cfg_rows_r};
    end
  end

  assign last_col = eff_cols - CUR_W'(1);
  assign last_row = eff_rows - CUR_W'(1);
  assign col_inc  = {1'b0, cur_col_r} + (CUR_W+1)'(1);
  assign line_inc = {1'b0, cur_row_r} + (CUR_W+1)'(1);

  // cell addresses: row * MAX_COLS + col, valid only inside the store
  assign cur_in_store = (cur_col_r < MAXC) && (cur_row_r < MAXR);
  assign pos_in_store = ({1'b0, in_col} < MAXC) && ({2'b0, in_row} < MAXR);
  assign cur_addr = AW'(cur_row_r) * ROW_STEP + AW'(cur_col_r);
  assign pos_addr = AW'(in_row) * ROW_STEP + AW'(in_col);

  assign in_acc  = in_tvalid && in_tready;
  assign rd_char = rd_ok_r ? ram_rdata[7:0]  : 8'd0;
  assign rd_attr = rd_ok_r ? ram_rdata[15:8] : 8'd0;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    cfg_cols_nxt  = cfg_cols_r;
    cfg_rows_nxt  = cfg_rows_r;
    cfg_attr_nxt  = cfg_attr_r;
    scrolled_nxt  = scrolled_r;
    rd_ok_nxt     = rd_ok_r;
    sc_col_nxt    = sc_col_r;
    sc_row_nxt    = sc_row_r;
    row_base_nxt  = row_base_r;
    wb_valid_nxt  = 1'b0;
    wb_addr_nxt   = wb_addr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    newline       = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    // configuration writes, taken in any state
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COLS: cfg_cols_nxt = cfg_wdata;
        CFG_ROWS: cfg_rows_nxt = cfg_wdata[6:0];
        CFG_ATTR: cfg_attr_nxt = cfg_wdata;
        default:  ;
      endcase
    end

    // output register drains
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // delayed write of a scroll copy
    if (wb_valid_r) begin
      ram_we    = 1'b1;
      ram_waddr = wb_addr_r;
      ram_wdata = ram_rdata;
    end

    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          state_nxt    = S_OUT;
          scrolled_nxt = 1'b0;
          rd_ok_nxt    = 1'b0;
          sc_col_nxt   = '0;
          sc_row_nxt   = '0;
          row_base_nxt = '0;
          case (in_cmd)
            CMD_PUT: begin
              if (in_char >= CH_PRINT) begin
                if (cur_in_store) begin
                  ram_we    = 1'b1;
                  ram_waddr = cur_addr;
                  ram_wdata = {cfg_attr_r, in_char};
                end
                if (col_inc >= {1'b0, eff_cols}) begin
                  newline = 1'b1;
                end else begin
                  cur_col_nxt = col_inc[CUR_W-1:0];
                end
              end else if (in_char == CH_LF) begin
                newline = 1'b1;
              end else if (in_char == CH_CR) begin
                cur_col_nxt = '0;
              end
            end
            CMD_SET: begin
              cur_col_nxt = ({1'b0, in_col} > last_col) ? last_col : {1'b0, in_col};
              cur_row_nxt = ({2'b0, in_row} > last_row) ? last_row : {2'b0, in_row};
            end
            CMD_WRITE: begin
              if (pos_in_store) begin
                ram_we    = 1'b1;
                ram_waddr = pos_addr;
                ram_wdata = {in_attr, in_char};
              end
            end
            CMD_READ: begin
              if (pos_in_store) begin
                ram_re    = 1'b1;
                ram_raddr = pos_addr;
                rd_ok_nxt = 1'b1;
              end
            end
            default: ;
          endcase
          if (newline) begin
            cur_col_nxt = '0;
            if (line_inc >= {1'b0, eff_rows}) begin
              cur_row_nxt  = last_row;
              scrolled_nxt = 1'b1;
              state_nxt    = (eff_rows == CUR_W'(1)) ? S_CLEAR : S_COPY;
            end else begin
              cur_row_nxt = line_inc[CUR_W-1:0];
            end
          end
        end
      end

      S_COPY: begin
        // read the cell one row below, write it back next cycle
        ram_re       = 1'b1;
        ram_raddr    = row_base_r + ROW_STEP + AW'(sc_col_r);
        wb_valid_nxt = 1'b1;
        wb_addr_nxt  = row_base_r + AW'(sc_col_r);
        if (sc_col_r == last_col) begin
          sc_col_nxt   = '0;
          sc_row_nxt   = sc_row_r + CUR_W'(1);
          row_base_nxt = row_base_r + ROW_STEP;
          if (sc_row_r == eff_rows - CUR_W'(2)) begin
            state_nxt = S_CLEAR;
          end
        end else begin
          sc_col_nxt = sc_col_r + CUR_W'(1);
        end
      end

      S_CLEAR: begin
        // waits until the last copy write has gone out
        if (!wb_valid_r) begin
          ram_we    = 1'b1;
          ram_waddr = row_base_r + AW'(sc_col_r);
          ram_wdata = '0;
          if (sc_col_r == last_col) begin
            state_nxt = S_OUT;
          end else begin
            sc_col_nxt = sc_col_r + CUR_W'(1);
          end
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, scrolled_r, rd_attr, rd_char,
                           cur_row_r[5:0], cur_col_r[6:0]};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_addr_r  <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      cfg_cols_r  <= COLS_RST;
      cfg_rows_r  <= ROWS_RST;
      cfg_attr_r  <= ATTR_RST;
      wb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      cfg_cols_r  <= cfg_cols_nxt;
      cfg_rows_r  <= cfg_rows_nxt;
      cfg_attr_r  <= cfg_attr_nxt;
      wb_valid_r  <= wb_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scrolled_r <= scrolled_nxt;
    rd_ok_r    <= rd_ok_nxt;
    sc_col_r   <= sc_col_nxt;
    sc_row_r   <= sc_row_nxt;
    row_base_r <= row_base_nxt;
    wb_addr_r  <= wb_addr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // cell store
  tcw_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

>>> hw/rtl/tcw_checker.sv
// port level checks of the text console cursor writer, bound to the top level
`default_nettype none

module tcw_checker
  import tcw_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a scroll only comes from a newline, which leaves the cursor at column 0
  a_scroll_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_SCRL_BIT] |->
      out_tdata[OUT_COL_LSB +: OUT_COL_W] == '0)
    else $error("scroll reported with cursor off column 0");

  // the clearing pass keeps the command channel closed after reset
  a_reset_closed: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("channel open right after reset");

  // one command at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command taken back to back");

endmodule

bind text_console_cursor_writer_top tcw_checker u_tcw_checker (.*);

`default_nettype wire

>>> test/console_checker.sv
// checker for the text console: mirrors the cell store and cursor, compares every result
module console_checker
  import tcw_pkg::*;
#(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // char_code[7:0], col[14:8], row[20:15], cell_attr[28:21]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // cursor_col[6:0], cursor_row[12:7], read_char[20:13],
                                  // read_attr[28:21], scrolled[29]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  output int          outstanding,
  output int          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [6:0] cur_col;
    logic [5:0] cur_row;
    logic [7:0] rd_char;
    logic [7:0] rd_attr;
    logic       scrolled;
  } console_report_t;

  logic [15:0]       cells [MAX_ROWS][MAX_COLS];
  logic [CUR_W-1:0]  cur_col;
  logic [CUR_W-1:0]  cur_row;
  logic [7:0]        cols_reg;
  logic [6:0]        rows_reg;
  logic [7:0]        attr_reg;
  console_report_t   due_reports [$];

  function automatic int used_cols();
    int c;
    c = cols_reg;
    if (c < 1) c = 1;
    if (c > MAX_COLS) c = MAX_COLS;
    return c;
  endfunction

  function automatic int used_rows();
    int r;
    r = rows_reg;
    if (r < 1) r = 1;
    if (r > MAX_ROWS) r = MAX_ROWS;
    return r;
  endfunction

  // only the visible area moves, the last visible row is blanked
  function automatic void shift_rows_up();
    int nc, nr;
    nc = used_cols();
    nr = used_rows();
    for (int r = 0; r + 1 < nr; r++)
      for (int c = 0; c < nc; c++)
        cells[r][c] = cells[r + 1][c];
    for (int c = 0; c < nc; c++)
      cells[nr - 1][c] = '0;
  endfunction

  function automatic bit take_new_line();
    int nr;
    nr = used_rows();
    cur_col = '0;
    if (cur_row + 1 >= nr) begin
      cur_row = CUR_W'(nr - 1);
      shift_rows_up();
      return 1'b1;
    end
    cur_row = cur_row + 1'b1;
    return 1'b0;
  endfunction

  function automatic console_report_t apply_console_cmd(cmd_t op, logic [7:0] ch,
                                                        logic [6:0] col, logic [5:0] row,
                                                        logic [7:0] attr);
    console_report_t rep;
    int last_col, last_row;
    rep = '0;
    case (op)
      CMD_PUT: begin
        if (ch >= CH_PRINT) begin
          if (cur_col < MAX_COLS && cur_row < MAX_ROWS)
            cells[cur_row][cur_col] = {attr_reg, ch};
          cur_col = cur_col + 1'b1;
          if (cur_col >= used_cols()) rep.scrolled = take_new_line();
        end else if (ch == CH_LF) begin
          rep.scrolled = take_new_line();
        end else if (ch == CH_CR) begin
          cur_col = '0;
        end
      end
      CMD_SET: begin
        last_col = used_cols() - 1;
        last_row = used_rows() - 1;
        cur_col = (int'(col) > last_col) ? CUR_W'(last_col) : CUR_W'(col);
        cur_row = (int'(row) > last_row) ? CUR_W'(last_row) : CUR_W'(row);
      end
      CMD_WRITE: begin
        if (col < MAX_COLS && row < MAX_ROWS) cells[row][col] = {attr, ch};
      end
      default: begin
        if (col < MAX_COLS && row < MAX_ROWS) begin
          rep.rd_char = cells[row][col][7:0];
          rep.rd_attr = cells[row][col][15:8];
        end
      end
    endcase
    rep.cur_col = cur_col[6:0];
    rep.cur_row = cur_row[5:0];
    return rep;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    console_report_t seen;
    console_report_t want;
    if (!rst_n) begin
      foreach (cells[r, c]) cells[r][c] = '0;
      cur_col  = '0;
      cur_row  = '0;
      cols_reg = COLS_RST;
      rows_reg = ROWS_RST;
      attr_reg = ATTR_RST;
      due_reports.delete();
      mismatches = 0;
    end else begin
      // a result can never belong to a command taken in the same cycle
      if (out_tvalid && out_tready) begin
        seen.cur_col  = out_tdata[OUT_COL_LSB +: OUT_COL_W];
        seen.cur_row  = out_tdata[OUT_ROW_LSB +: OUT_ROW_W];
        seen.rd_char  = out_tdata[20:13];
        seen.rd_attr  = out_tdata[28:21];
        seen.scrolled = out_tdata[OUT_SCRL_BIT];
        if (due_reports.size() == 0) begin
          $error("result transaction with no command waiting for it");
          mismatches++;
        end else begin
          want = due_reports.pop_front();
          check_field("cursor_col", want.cur_col, seen.cur_col);
          check_field("cursor_row", want.cur_row, seen.cur_row);
          check_field("read_char", want.rd_char, seen.rd_char);
          check_field("read_attr", want.rd_attr, seen.rd_attr);
          check_field("scrolled", want.scrolled, seen.scrolled);
        end
      end
      if (in_tvalid && in_tready)
        due_reports.push_back(apply_console_cmd(cmd_t'(in_tuser), in_tdata[7:0],
                                                in_tdata[14:8], in_tdata[20:15],
                                                in_tdata[28:21]));
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_COLS: cols_reg = cfg_wdata;
          CFG_ROWS: rows_reg = cfg_wdata[6:0];
          CFG_ATTR: attr_reg = cfg_wdata;
          default: ;
        endcase
      end
    end
    outstanding = due_reports.size();
  end

endmodule

>>> test/testbench.sv
// top of the console testbench: clock, reset, command stimulus, result back-pressure, verdict
module testbench import tcw_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_COLS = 128;
  localparam int GRID_ROWS = 64;

  // one screen geometry and attribute per phase, with its number of random commands
  typedef struct {
    logic [7:0] cols;
    logic [6:0] rows;
    logic [7:0] attr;
    int         items;
  } screen_setup_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;    // char_code[7:0], col[14:8], row[20:15], cell_attr[28:21]
  logic [1:0]  in_tuser;    // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // cursor_col[6:0], cursor_row[12:7], read_char[20:13],
                            // read_attr[28:21], scrolled[29]
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;
  int          outstanding;
  int          mismatches;

  // visible area as the block sees it after saturation, used to aim coordinates
  int          shown_cols;
  int          shown_rows;
  // commands still to go out back to back, for stretches with no gaps
  int          calm_items;
  screen_setup_t setups [9];

  always #6 clk = ~clk;

  text_console_cursor_writer_top #(
    .MAX_COLS (GRID_COLS),
    .MAX_ROWS (GRID_ROWS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  console_checker #(
    .MAX_COLS (GRID_COLS),
    .MAX_ROWS (GRID_ROWS)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  // idle cycles before the next command: mostly none or short, now and then long,
  // and sometimes a run of commands with no gap at all
  function automatic int pick_gap();
    int r;
    if (calm_items > 0) begin
      calm_items--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_items = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // one command transaction; entered and left at a falling edge, tvalid stays high
  // when the next command follows with no gap
  task automatic send_cmd(cmd_t op, logic [7:0] ch, logic [6:0] col, logic [5:0] row,
                          logic [7:0] attr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {3'b000, attr, row, col, ch};
    in_tuser  = op;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // mostly running text with line breaks, the rest cursor moves and cell pokes
  task automatic send_random_cmd();
    int r;
    cmd_t op;
    logic [7:0] ch;
    logic [6:0] col;
    logic [5:0] row;
    r = $urandom_range(0, 99);
    if (r < 60)      op = CMD_PUT;
    else if (r < 70) op = CMD_SET;
    else if (r < 85) op = CMD_WRITE;
    else             op = CMD_READ;
    r = $urandom_range(0, 99);
    if (r < 75)      ch = 8'($urandom_range(32, 255));
    else if (r < 87) ch = CH_LF;
    else if (r < 93) ch = CH_CR;
    else             ch = 8'($urandom_range(0, 31));
    // aim inside the visible area most of the time so reads see printed text
    if ($urandom_range(0, 9) < 6) begin
      col = 7'($urandom_range(0, shown_cols - 1));
      row = 6'($urandom_range(0, shown_rows - 1));
    end else begin
      col = 7'($urandom_range(0, GRID_COLS - 1));
      row = 6'($urandom_range(0, GRID_ROWS - 1));
    end
    send_cmd(op, ch, col, row, 8'($urandom_range(0, 255)));
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // let every result come home before the registers change; a scroll at full
  // size is the slowest thing the block does, the guard allows for it
  task automatic drain_results();
    int guard;
    in_tvalid = 1'b0;
    guard = 0;
    while (outstanding != 0 && guard < 50000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
  endtask

  // result side: a long hold-off once the clearing pass is over, so that the
  // block fills up while the sender keeps offering, then random back-pressure
  initial begin
    int wait_left;
    int free_left;
    int r;
    out_tready = 1'b0;
    wait_left  = 0;
    free_left  = 0;
    do @(posedge clk); while (!(rst_n && in_tready));
    repeat (300) @(posedge clk);
    forever begin
      @(negedge clk);
      if (free_left > 0) begin
        out_tready = 1'b1;
        free_left--;
      end else if (wait_left > 0) begin
        out_tready = 1'b0;
        wait_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          out_tready = 1'b1;
          free_left  = $urandom_range(40, 120);
        end else if (r < 70) begin
          out_tready = 1'b1;
        end else if (r < 90) begin
          out_tready = 1'b0;
          wait_left  = $urandom_range(0, 2);
        end else if (r < 97) begin
          out_tready = 1'b0;
          wait_left  = $urandom_range(3, 9);
        end else begin
          out_tready = 1'b0;
          wait_left  = $urandom_range(20, 60);
        end
      end
    end
  end

  // hang guard, well beyond the slowest legal run
  initial begin
    #200_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_PUT;
    cfg_we     = 1'b0;
    cfg_index  = CFG_COLS;
    cfg_wdata  = '0;
    calm_items = 0;
    shown_cols = COLS_RST;
    shown_rows = ROWS_RST;
    // geometries: small, the smallest, zero (counts as one), the full store,
    // above the store (saturates), then ordinary ones
    setups = '{
      '{8'd4,   7'd3,   8'hA5, 60},
      '{8'd1,   7'd1,   8'h00, 25},
      '{8'd0,   7'd0,   8'hFF, 20},
      '{8'd128, 7'd64,  8'h5A, 30},
      '{8'd255, 7'd127, 8'h3C, 15},
      '{8'd16,  7'd8,   8'hC3, 80},
      '{8'd7,   7'd2,   8'h81, 60},
      '{8'd3,   7'd64,  8'h12, 40},
      '{8'd80,  7'd25,  8'h0F, 50}
    };
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed part at the reset geometry of 80 by 25, attribute 0x0F;
    // the clearing pass holds in_tready low until the store is blank
    send_cmd(CMD_READ,  8'd0,   7'd0,   6'd0,  8'd0);    // blank cell after reset
    send_cmd(CMD_PUT,   8'd65,  7'd0,   6'd0,  8'd0);
    send_cmd(CMD_PUT,   8'd255, 7'd0,   6'd0,  8'd0);    // top of the extended range
    send_cmd(CMD_PUT,   CH_PRINT, 7'd0, 6'd0,  8'd0);    // lowest printable code
    send_cmd(CMD_PUT,   8'd31,  7'd0,   6'd0,  8'd0);    // control codes are ignored
    send_cmd(CMD_PUT,   8'd0,   7'd0,   6'd0,  8'd0);
    send_cmd(CMD_PUT,   CH_CR,  7'd0,   6'd0,  8'd0);
    send_cmd(CMD_PUT,   CH_LF,  7'd0,   6'd0,  8'd0);
    // far corner of the store lies outside the visible area but still holds data
    send_cmd(CMD_WRITE, 8'hFF,  7'd127, 6'd63, 8'hFF);
    send_cmd(CMD_READ,  8'd0,   7'd127, 6'd63, 8'd0);
    send_cmd(CMD_READ,  8'd0,   7'd1,   6'd0,  8'd0);
    send_cmd(CMD_WRITE, 8'd90,  7'd5,   6'd24, 8'hF0);
    // cursor set past the edges saturates to the last visible cell
    send_cmd(CMD_SET,   8'd0,   7'd127, 6'd63, 8'd0);
    // printing in the bottom-right cell wraps and scrolls
    send_cmd(CMD_PUT,   8'd120, 7'd0,   6'd0,  8'd0);
    send_cmd(CMD_READ,  8'd0,   7'd5,   6'd23, 8'd0);
    send_cmd(CMD_READ,  8'd0,   7'd79,  6'd23, 8'd0);
    // line feed on the bottom row scrolls as well
    send_cmd(CMD_SET,   8'd0,   7'd0,   6'd24, 8'd0);
    send_cmd(CMD_PUT,   CH_LF,  7'd0,   6'd0,  8'd0);
    // wrap at the width without a scroll
    send_cmd(CMD_SET,   8'd0,   7'd78,  6'd3,  8'd0);
    send_cmd(CMD_PUT,   8'd97,  7'd0,   6'd0,  8'd0);
    send_cmd(CMD_PUT,   8'd98,  7'd0,   6'd0,  8'd0);
    send_cmd(CMD_READ,  8'd0,   7'd79,  6'd3,  8'd0);
    send_cmd(CMD_SET,   8'd0,   7'd0,   6'd0,  8'd0);
    drain_results();

    // random phases; each ends with the cursor pushed to the last visible cell,
    // so a following smaller screen starts with the cursor outside it
    foreach (setups[p]) begin
      write_reg(CFG_COLS, setups[p].cols);
      write_reg(CFG_ROWS, setups[p].rows);
      write_reg(CFG_ATTR, setups[p].attr);
      shown_cols = (setups[p].cols == 0) ? 1 :
                   (setups[p].cols > GRID_COLS) ? GRID_COLS : setups[p].cols;
      shown_rows = (setups[p].rows == 0) ? 1 :
                   (setups[p].rows > GRID_ROWS) ? GRID_ROWS : setups[p].rows;
      for (int i = 0; i < setups[p].items - 1; i++) send_random_cmd();
      send_cmd(CMD_SET, 8'($urandom_range(0, 255)), 7'd127, 6'd63,
               8'($urandom_range(0, 255)));
      drain_results();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench OK");
    end else begin
      if (outstanding != 0) $error("%0d results never arrived", outstanding);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
